// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, muted while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same check, also active during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bdlps_pkg.sv =====
`default_nettype none

package bdlps_pkg;

   localparam int TIME_WIDTH          = 32;
   localparam int CSR_WIDTH           = 16;
   localparam int CSR_INDEX_WIDTH     = 1;
   localparam int MASK_WIDTH          = 3;
   localparam int BUTTON_WIDTH        = 2;
   localparam int HELD_EXT_WIDTH      = 1 << BUTTON_WIDTH;
   localparam int NUM_BUTTONS_DEFAULT = 3;

   localparam logic [CSR_WIDTH-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CSR_WIDTH-1:0] LONG_PRESS_RESET = 16'd400;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEBOUNCE   = 1'b0,
      CSR_LONG_PRESS = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

// ===== hw/rtl/button_debounce_long_press_selector.sv =====
// Button debounce and long-press selector. One service tick is a transfer on the req_ channel
// and yields exactly one transfer on the rsp_ channel; a tick passes through the input register
// and then the single pass into the result register, and a new tick is taken every cycle while
// rsp_ready is high. Press edges are debounced per button against that button's last accepted
// edge; the lowest accepted button becomes active when armed and no press is pending. Holding
// it for long_press_ms issues a long selection immediately; a release issues the selection
// debounce_ms later, long or short by hold time. Timestamps wrap mod 2^32. Registers: index 0
// debounce_ms, index 1 long_press_ms. The user writes them only while idle; no code enforces it.
`default_nettype none
`include "assert_macros.svh"

module button_debounce_long_press_selector #(
   parameter int NUM_BUTTONS = bdlps_pkg::NUM_BUTTONS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,

   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [bdlps_pkg::TIME_WIDTH-1:0]       req_now_ms,
   input  wire logic [bdlps_pkg::MASK_WIDTH-1:0]       req_press_mask,
   input  wire logic [bdlps_pkg::MASK_WIDTH-1:0]       req_held_mask,
   input  wire logic                                   req_armed,
   input  wire logic                                   req_cancel,

   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic                                        rsp_select_valid,
   output logic [bdlps_pkg::BUTTON_WIDTH-1:0]          rsp_select_button,
   output logic                                        rsp_select_long,

   input  wire logic                                   csr_write_enable,
   input  wire logic [bdlps_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [bdlps_pkg::CSR_WIDTH-1:0]        csr_write_data
);

   localparam int TW = bdlps_pkg::TIME_WIDTH;
   localparam int BW = bdlps_pkg::BUTTON_WIDTH;
   localparam int MW = bdlps_pkg::MASK_WIDTH;
   localparam int NUM_LANES = (NUM_BUTTONS < MW) ? NUM_BUTTONS : MW;

   // configuration
   logic [bdlps_pkg::CSR_WIDTH-1:0] debounce_ff, debounce_in;
   logic [bdlps_pkg::CSR_WIDTH-1:0] long_press_ff, long_press_in;

   // input register
   logic          in_valid_ff, in_valid_in;
   logic [TW-1:0] in_now_ff, in_now_in;
   logic [MW-1:0] in_press_ff, in_press_in;
   logic [MW-1:0] in_held_ff, in_held_in;
   logic          in_armed_ff, in_armed_in;
   logic          in_cancel_ff, in_cancel_in;

   // tracking state
   logic [TW-1:0] last_time_ff [NUM_LANES];
   logic [TW-1:0] last_time_in [NUM_LANES];
   logic [NUM_LANES-1:0] last_valid_ff, last_valid_in;
   logic [TW-1:0] press_time_ff, press_time_in;
   logic [TW-1:0] release_time_ff, release_time_in;
   logic [BW-1:0] active_ff, active_in;
   logic          press_pending_ff, press_pending_in;
   logic          release_pending_ff, release_pending_in;

   // result register
   logic          out_valid_ff, out_valid_in;
   logic          out_select_ff, out_select_in;
   logic [BW-1:0] out_button_ff, out_button_in;
   logic          out_long_ff, out_long_in;

   logic                 advance;
   logic [NUM_LANES-1:0] pass;
   logic [BW-1:0]        first_lane;
   logic                 pend0, rel0, start, pend1, rel1;
   logic [BW-1:0]        active1;
   logic [TW-1:0]        ptime1;
   logic [bdlps_pkg::HELD_EXT_WIDTH-1:0] held_ext;
   logic                 held_bit;
   logic [TW-1:0]        hold_time, rel_elapsed, hold_at_release;
   logic                 fire, is_long;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid         = out_valid_ff;
   assign rsp_select_valid  = out_select_ff;
   assign rsp_select_button = out_button_ff;
   assign rsp_select_long   = out_long_ff;

   always_comb begin
      debounce_in   = debounce_ff;
      long_press_in = long_press_ff;
      if (csr_write_enable) begin
         unique case (bdlps_pkg::csr_index_type'(csr_index))
            bdlps_pkg::CSR_DEBOUNCE:   debounce_in   = csr_write_data;
            bdlps_pkg::CSR_LONG_PRESS: long_press_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_now_in    = in_now_ff;
      in_press_in  = in_press_ff;
      in_held_in   = in_held_ff;
      in_armed_in  = in_armed_ff;
      in_cancel_in = in_cancel_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in  = 1'b1;
         in_now_in    = req_now_ms;
         in_press_in  = req_press_mask;
         in_held_in   = req_held_mask;
         in_armed_in  = req_armed;
         in_cancel_in = req_cancel;
      end
   end

   // single pass over one tick
   always_comb begin
      pend0 = press_pending_ff && !in_cancel_ff;
      rel0  = release_pending_ff && !in_cancel_ff;

      for (int i = 0; i < NUM_LANES; i++) begin
         pass[i] = in_press_ff[i] && (!last_valid_ff[i] ||
                   ((in_now_ff - last_time_ff[i]) >= TW'(debounce_ff)));
      end

      first_lane = '0;
      for (int i = NUM_LANES - 1; i >= 0; i--) begin
         if (pass[i]) begin
            first_lane = BW'(i);
         end
      end

      start   = in_armed_ff && !pend0 && (|pass);
      pend1   = pend0 || start;
      rel1    = start ? 1'b0 : rel0;
      active1 = start ? first_lane : active_ff;
      ptime1  = start ? in_now_ff : press_time_ff;

      held_ext        = bdlps_pkg::HELD_EXT_WIDTH'(in_held_ff);
      held_bit        = held_ext[active1];
      hold_time       = in_now_ff - ptime1;
      rel_elapsed     = in_now_ff - release_time_ff;
      hold_at_release = release_time_ff - ptime1;

      fire               = 1'b0;
      is_long            = 1'b0;
      release_pending_in = rel1;
      release_time_in    = release_time_ff;
      if (pend1) begin
         if (held_bit) begin
            release_pending_in = 1'b0;
            if (hold_time >= TW'(long_press_ff)) begin
               fire    = 1'b1;
               is_long = 1'b1;
            end
         end else if (!rel1) begin
            release_time_in    = in_now_ff;
            release_pending_in = 1'b1;
         end else if (rel_elapsed >= TW'(debounce_ff)) begin
            fire    = 1'b1;
            is_long = hold_at_release >= TW'(long_press_ff);
         end
      end

      press_pending_in = pend1 && !fire;
      if (fire) begin
         release_pending_in = 1'b0;
      end
      active_in     = active1;
      press_time_in = ptime1;

      for (int i = 0; i < NUM_LANES; i++) begin
         last_time_in[i]  = pass[i] ? in_now_ff : last_time_ff[i];
         last_valid_in[i] = last_valid_ff[i] || pass[i];
      end

      out_select_in = fire;
      out_button_in = fire ? active1 : '0;
      out_long_in   = fire && is_long;
      out_valid_in  = advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      in_now_ff    <= in_now_in;
      in_press_ff  <= in_press_in;
      in_held_ff   <= in_held_in;
      in_armed_ff  <= in_armed_in;
      in_cancel_ff <= in_cancel_in;
      if (advance) begin
         last_time_ff    <= last_time_in;
         press_time_ff   <= press_time_in;
         release_time_ff <= release_time_in;
         active_ff       <= active_in;
         out_select_ff   <= out_select_in;
         out_button_ff   <= out_button_in;
         out_long_ff     <= out_long_in;
      end
      if (reset) begin
         debounce_ff        <= bdlps_pkg::DEBOUNCE_RESET;
         long_press_ff      <= bdlps_pkg::LONG_PRESS_RESET;
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         last_valid_ff      <= '0;
         press_pending_ff   <= 1'b0;
         release_pending_ff <= 1'b0;
      end else begin
         debounce_ff   <= debounce_in;
         long_press_ff <= long_press_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         if (advance) begin
            last_valid_ff      <= last_valid_in;
            press_pending_ff   <= press_pending_in;
            release_pending_ff <= release_pending_in;
         end
      end
   end

   // checks
   `ASSERT_CLK(a_release_needs_press, clock, reset,
      release_pending_ff |-> press_pending_ff, "release pending without a pending press")
   `ASSERT_CLK(a_idle_result_zero, clock, reset,
      (out_valid_ff && !out_select_ff) |-> (out_button_ff == '0 && !out_long_ff),
      "non-selection result carries nonzero fields")
   `ASSERT_CLK(a_button_in_range, clock, reset,
      (out_valid_ff && out_select_ff) |-> (out_button_ff < NUM_LANES),
      "selected button out of range")
   `ASSERT_CLK(a_select_clears_press, clock, reset,
      (advance && fire) |=> (!release_pending_ff),
      "release still pending after a selection")

endmodule

`default_nettype wire
